// File: sv/hash_bucketed_top_k_table_assert.svh
// Assertion macros for the hash-bucketed top-k table.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef HASH_BUCKETED_TOP_K_TABLE_ASSERT_SVH
`define HASH_BUCKETED_TOP_K_TABLE_ASSERT_SVH
`ifndef SYNTH
`define HTK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("htk assertion failed");
`define HTK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htk assertion failed");
`else
`define HTK_ASSERT(lbl, prop)
`define HTK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/htk_pkg.sv
// Package for the hash-bucketed top-k table: sizes, entry and row types,
// controller states and the command and status groups. No dependencies.
package htk_pkg;

    localparam int BKT_IDX_BITS = 10;
    localparam int TOP_SLOTS    = 4;
    localparam int ENTRIES      = TOP_SLOTS + 1;
    localparam int NUM_BUCKETS  = 1 << BKT_IDX_BITS;
    localparam int ADDR_W       = BKT_IDX_BITS;
    localparam int HASH_W       = 32;
    localparam int CNT_W        = 32;
    localparam int TAG_W        = HASH_W - BKT_IDX_BITS;
    localparam int BUCKET_W     = 10;
    localparam int SLOT_W       = 2;
    localparam int CB_W         = 6;
    localparam int TLEN_W       = 7;
    localparam int EIDX_W       = $clog2(ENTRIES);
    localparam int RANK_W       = $clog2(ENTRIES);

    localparam logic [TLEN_W-1:0] TAG_LIMIT_BASE   = 7'd72;
    localparam logic [CB_W-1:0]   COUNT_BITS_RESET = 6'd32;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    typedef entry_t [ENTRIES-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MERGE = 6'b000100,
        S_SORT  = 6'b001000,
        S_RESP  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic rd_en;
        logic merge_en;
        logic sort_wr;
        logic resp;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic is_neg;
    } status_t;

endpackage

// File: sv/htk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module htk_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/htk_dp.sv
// Datapath of the hash-bucketed top-k table: bucket store, tag match,
// stable rank sort and read response. Depends on htk_pkg and htk_ram.
module htk_dp
    import htk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  action,
    input  logic [HASH_W-1:0]     hash_value,
    input  logic signed [CNT_W-1:0] count,
    input  logic [BUCKET_W-1:0]   bucket,
    input  logic [SLOT_W-1:0]     slot,
    input  logic                  cfg_we,
    input  logic [CB_W-1:0]       cfg_wdata,
    output logic                  done,
    output logic [CNT_W-1:0]      count_value
);

    logic [CB_W-1:0]   count_bits_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] slot_reg;
    row_t              merged_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_value_reg;

    logic [TLEN_W-1:0] tag_len;
    logic [TAG_W-1:0]  tag_mask;
    logic [CNT_W-1:0]  cnt_mask;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [ROW_W-1:0]  rdata;
    row_t              row_in;
    row_t              merged_next;
    row_t              sorted;
    row_t              wrow;
    entry_t            rd_entry;
    logic [CNT_W-1:0]  count_value_next;
    logic [RANK_W-1:0] rank [ENTRIES];
    logic              hit;

    assign status.clear_done = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign status.is_read    = (action == ACT_READ);
    assign status.is_neg     = count[CNT_W-1];

    assign tag_len = TAG_LIMIT_BASE - TLEN_W'(count_bits_reg);

    always_comb
    begin
        for (int b = 0; b < TAG_W; b++)
        begin
            tag_mask[b] = (TLEN_W'(b) < tag_len);
        end
        for (int b = 0; b < CNT_W; b++)
        begin
            cnt_mask[b] = (CB_W'(b) < count_bits_reg);
        end
    end

    assign raddr = (action == ACT_READ) ? ADDR_W'(bucket) : hash_value[ADDR_W-1:0];
    assign waddr = cmd.clear_wr ? clr_cnt_reg : idx_reg;
    assign we    = cmd.clear_wr | cmd.sort_wr;
    assign wrow  = cmd.clear_wr ? '0 : sorted;

    htk_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (NUM_BUCKETS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrow),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign row_in = row_t'(rdata);

    always_comb
    begin
        merged_next = row_in;
        hit         = 1'b0;
        for (int i = 0; i < TOP_SLOTS; i++)
        begin
            if (row_in[i].valid && (row_in[i].tag == tag_reg))
            begin
                merged_next[i].cnt = cnt_reg;
                hit                = 1'b1;
            end
        end
        if (!hit)
        begin
            merged_next[TOP_SLOTS].valid = 1'b1;
            merged_next[TOP_SLOTS].tag   = tag_reg;
            merged_next[TOP_SLOTS].cnt   = cnt_reg;
        end
    end

    // stable descending sort: rank each entry by those that precede it
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (j < i && merged_reg[j].cnt >= merged_reg[i].cnt)
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
                else if (j > i && merged_reg[j].cnt > merged_reg[i].cnt)
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        sorted = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (rank[i] == RANK_W'(k))
                begin
                    sorted[k] = sorted[k] | merged_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        rd_entry         = row_in[EIDX_W'(slot_reg)];
        count_value_next = '0;
        if ((int'(slot_reg) < TOP_SLOTS) && rd_entry.valid)
        begin
            count_value_next = rd_entry.cnt & cnt_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_bits_reg <= COUNT_BITS_RESET;
            clr_cnt_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_bits_reg <= cfg_wdata;
            end
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            done_reg <= cmd.resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= hash_value[ADDR_W-1:0];
            tag_reg  <= hash_value[HASH_W-1:BKT_IDX_BITS] & tag_mask;
            cnt_reg  <= count;
            slot_reg <= slot;
        end
        if (cmd.merge_en)
        begin
            merged_reg <= merged_next;
        end
        if (cmd.resp)
        begin
            count_value_reg <= count_value_next;
        end
    end

    assign done        = done_reg;
    assign count_value = count_value_reg;

endmodule

// File: sv/htk_ctrl.sv
// Controller of the hash-bucketed top-k table: clearing pass, item accept
// and sequencing of read, merge, sort and response. Depends on htk_pkg.
module htk_ctrl
    import htk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    cmd.rd_en   = 1'b1;
                    if (status.is_read)
                    begin
                        state_next = S_RESP;
                    end
                    else if (!status.is_neg)
                    begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                cmd.merge_en = 1'b1;
                state_next   = S_SORT;
            end
            S_SORT:
            begin
                cmd.sort_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_RESP:
            begin
                cmd.resp   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: sv/hash_bucketed_top_k_table.sv
// Channel   Handshake            Payload
// item in   start / busy         action, hash_value, count, bucket, slot
// result    done (one cycle)     count_value
// config    cfg_we               cfg_wdata (count_bits)
//
// A read holds busy in S_RESP and its result appears on the cycle after;
// the next item can be taken once the controller returns to S_IDLE.
// An add: bucket row read, merge in S_MERGE, sort and write back in S_SORT.
// An add with a negative count stays in S_IDLE and changes nothing.
// After reset the store is cleared one bucket a cycle, busy high throughout.
// Results cannot be stalled; done is high for exactly one cycle.
//
// Top level of the hash-bucketed top-k table; depends on htk_pkg, htk_ctrl,
// htk_dp and the assertion macro header.
`include "hash_bucketed_top_k_table_assert.svh"
module hash_bucketed_top_k_table
    import htk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    action,
    input  logic [HASH_W-1:0]       hash_value,
    input  logic signed [CNT_W-1:0] count,
    input  logic [BUCKET_W-1:0]     bucket,
    input  logic [SLOT_W-1:0]       slot,
    input  logic                    cfg_we,
    input  logic [CB_W-1:0]         cfg_wdata,
    output logic                    done,
    output logic [CNT_W-1:0]        count_value
);

    cmd_t    cmd;
    status_t status;

    htk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    htk_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .hash_value  (hash_value),
        .count       (count),
        .bucket      (bucket),
        .slot        (slot),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .count_value (count_value)
    );

    `HTK_ASSERT_NEXT(a_read_resp, start && !busy && action, cmd.resp)
    `HTK_ASSERT_NEXT(a_resp_done, cmd.resp, done)
    `HTK_ASSERT(a_done_src, done |-> $past(cmd.resp))
    `HTK_ASSERT_NEXT(a_merge_sort, cmd.merge_en, cmd.sort_wr && busy)

endmodule

// File: test/tb_hash_bucketed_top_k_table.sv
// Self-checking testbench for hash_bucketed_top_k_table: directed and random add/read
// items over several count widths, checked against an in-bench bucket predictor.
// Depends on htk_pkg and the hash_bucketed_top_k_table RTL only.
`timescale 1ns / 100ps

module tb_hash_bucketed_top_k_table;
    import htk_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    action;
    logic [HASH_W-1:0]       hash_value;
    logic signed [CNT_W-1:0] count;
    logic [BUCKET_W-1:0]     bucket;
    logic [SLOT_W-1:0]       slot;
    logic                    cfg_we;
    logic [CB_W-1:0]         cfg_wdata;
    logic                    done;
    logic [CNT_W-1:0]        count_value;

    entry_t            bucket_store [NUM_BUCKETS][ENTRIES];
    logic [CB_W-1:0]   count_bits_model;
    logic [CNT_W-1:0]  expected_counts [$];

    int  cycle_count;
    int  mismatch_count;
    int  items_sent;
    int  reads_checked;
    int  widths_used;
    bit  gaps_on;

    logic [TAG_W-1:0]    hot_tags [8] = '{22'h0, 22'h1, 22'h2, 22'h3, 22'h201, 22'h3FFE01,
                                          22'h3FFFFF, 22'h155};
    logic [BUCKET_W-1:0] hot_buckets [4] = '{10'd0, 10'd5, 10'd512, 10'd1023};

    hash_bucketed_top_k_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .hash_value  (hash_value),
        .count       (count),
        .bucket      (bucket),
        .slot        (slot),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .count_value (count_value)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_counts.size());
            $display("hash_bucketed_top_k_table test failed");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] width_mask(input int bits);
        if (bits >= CNT_W)
            return '1;
        if (bits <= 0)
            return '0;
        return (32'd1 << bits) - 32'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] exp_v,
                                   input logic [CNT_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s expected %08h got %08h",
                     cycle_count, what, exp_v, got_v);
    endtask

    // Result checker: pop the oldest expected count on each done strobe
    always @(posedge clk)
    begin
        logic [CNT_W-1:0] want;
        if (rst_n && done)
        begin
            if (expected_counts.size() == 0)
                report_mismatch("unexpected result, count_value", '0, count_value);
            else
            begin
                want = expected_counts.pop_front();
                reads_checked++;
                if (count_value !== want)
                    report_mismatch("count_value", want, count_value);
            end
        end
    end

    function automatic void clear_bucket_store();
        for (int b = 0; b < NUM_BUCKETS; b++)
            for (int e = 0; e < ENTRIES; e++)
                bucket_store[b][e] = '0;
    endfunction

    function automatic void apply_add(input logic [HASH_W-1:0] hv, input logic [CNT_W-1:0] cv);
        int          idx;
        int          j;
        logic [31:0] tag32;
        logic        hit;
        entry_t      row [ENTRIES];
        entry_t      moving;
        if (cv[CNT_W-1])
            return;
        idx   = hv[ADDR_W-1:0];
        tag32 = (hv >> BKT_IDX_BITS)
                & width_mask(int'(TAG_LIMIT_BASE) - int'(count_bits_model));
        hit   = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            row[i] = bucket_store[idx][i];
        for (int i = 0; i < TOP_SLOTS; i++)
        begin
            if (row[i].valid && row[i].tag == tag32[TAG_W-1:0])
            begin
                row[i].cnt = cv;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            row[TOP_SLOTS].valid = 1'b1;
            row[TOP_SLOTS].tag   = tag32[TAG_W-1:0];
            row[TOP_SLOTS].cnt   = cv;
        end
        // stable insertion sort, largest count first
        for (int i = 1; i < ENTRIES; i++)
        begin
            moving = row[i];
            j = i;
            while (j > 0 && row[j-1].cnt < moving.cnt)
            begin
                row[j] = row[j-1];
                j--;
            end
            row[j] = moving;
        end
        for (int i = 0; i < ENTRIES; i++)
            bucket_store[idx][i] = row[i];
    endfunction

    function automatic logic [CNT_W-1:0] predict_read(input logic [BUCKET_W-1:0] bkt,
                                                      input logic [SLOT_W-1:0] pos);
        entry_t e;
        if (int'(pos) >= TOP_SLOTS)
            return '0;
        e = bucket_store[bkt & (NUM_BUCKETS - 1)][pos];
        if (!e.valid)
            return '0;
        return e.cnt & width_mask(int'(count_bits_model));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic send_item(input logic act, input logic [HASH_W-1:0] hv,
                             input logic [CNT_W-1:0] cv, input logic [BUCKET_W-1:0] bkt,
                             input logic [SLOT_W-1:0] pos);
        int gap;
        action     = act;
        hash_value = hv;
        count      = cv;
        bucket     = bkt;
        slot       = pos;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (act == ACT_READ)
            expected_counts.insert(expected_counts.size(), predict_read(bkt, pos));
        else
            apply_add(hv, cv);
        items_sent++;
        @(negedge clk);
        start = 1'b0;
        gap = gaps_on ? pick_gap() : 0;
        repeat (gap)
            @(negedge clk);
    endtask

    task automatic add_item(input logic [HASH_W-1:0] hv, input logic [CNT_W-1:0] cv);
        send_item(ACT_ADD, hv, cv, BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1)),
                  SLOT_W'($urandom_range(0, 3)));
    endtask

    task automatic read_item(input logic [BUCKET_W-1:0] bkt, input logic [SLOT_W-1:0] pos);
        send_item(ACT_READ, $urandom(), $urandom(), bkt, pos);
    endtask

    task automatic wait_for_results();
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count_bits(input logic [CB_W-1:0] width);
        wait_for_results();
        cfg_we    = 1'b1;
        cfg_wdata = width;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = CB_W'($urandom());
        count_bits_model = width;
        widths_used++;
    endtask

    task automatic read_whole_bucket(input logic [BUCKET_W-1:0] bkt);
        for (int s = 0; s < TOP_SLOTS; s++)
            read_item(bkt, SLOT_W'(s));
    endtask

    task automatic test_reads_after_reset();
        read_item(10'd0, 2'd0);
        read_item(10'd1023, 2'd3);
        read_item(BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1)), 2'd1);
    endtask

    task automatic test_add_extremes();
        add_item(32'h0000_0000, 32'h0000_0000);
        add_item(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(32'h0000_0400, 32'h8000_0000);
        read_item(10'd0, 2'd0);
        read_item(10'd1023, 2'd0);
        // fill one bucket with ties, force an eviction, then lower a count
        add_item({22'h1, 10'd5}, 32'd10);
        add_item({22'h2, 10'd5}, 32'd20);
        add_item({22'h3, 10'd5}, 32'd20);
        add_item({22'h4, 10'd5}, 32'd5);
        add_item({22'h5, 10'd5}, 32'd30);
        add_item({22'h2, 10'd5}, 32'd1);
        read_whole_bucket(10'd5);
    endtask

    task automatic test_count_width();
        write_count_bits(6'd8);
        read_item(10'd1023, 2'd0);
        write_count_bits(6'd0);
        read_item(10'd5, 2'd0);
        write_count_bits(6'd63);
        add_item({22'h3FFE01, 10'd5}, 32'hDEAD_BEEF);
        add_item({22'h000001, 10'd5}, 32'd7);
        read_whole_bucket(10'd5);
    endtask

    task automatic random_item();
        logic [BUCKET_W-1:0] bkt;
        logic [TAG_W-1:0]    tag;
        logic [CNT_W-1:0]    cv;
        int                  r;
        bkt = ($urandom_range(0, 9) < 7) ? hot_buckets[$urandom_range(0, 3)]
                                         : BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1));
        if ($urandom_range(0, 99) < 35)
        begin
            read_item(bkt, SLOT_W'($urandom_range(0, 3)));
            return;
        end
        tag = ($urandom_range(0, 9) < 7) ? hot_tags[$urandom_range(0, 7)]
                                         : TAG_W'($urandom());
        r = $urandom_range(0, 9);
        if (r < 4)
            cv = $urandom_range(0, 6);
        else if (r < 8)
            cv = $urandom() & 32'h7FFF_FFFF;
        else if (r == 8)
            cv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
        else
            cv = $urandom() | 32'h8000_0000;
        add_item({tag, bkt}, cv);
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            gaps_on = (i % 64) >= 16;
            random_item();
            if ($urandom_range(0, 59) == 0)
                wait_for_results();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 20; i++)
            random_item();
        wait_for_results();
        for (int i = 0; i < 20; i++)
            random_item();
    endtask

    initial
    begin
        logic [CB_W-1:0] widths [10];
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_ADD;
        hash_value = '0;
        count      = '0;
        bucket     = '0;
        slot       = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        items_sent     = 0;
        reads_checked  = 0;
        widths_used    = 1;
        gaps_on        = 1'b1;
        count_bits_model = COUNT_BITS_RESET;
        clear_bucket_store();
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        test_reads_after_reset();
        test_add_extremes();
        test_count_width();
        write_count_bits(COUNT_BITS_RESET);
        test_pause_until_drained();

        widths = '{6'd32, 6'd8, 6'd0, 6'd63, 6'd31, 6'd50, 6'd51, 6'd40, 6'd1, 6'd32};
        widths[8] = CB_W'($urandom_range(1, 63));
        foreach (widths[w])
        begin
            write_count_bits(widths[w]);
            test_random_traffic(95);
        end

        wait_for_results();
        $display("Covered %0d items, %0d read results checked, %0d count width settings",
                 items_sent, reads_checked, widths_used);
        if (mismatch_count == 0)
            $display("hash_bucketed_top_k_table test passed");
        else
            $display("hash_bucketed_top_k_table test failed");
        $finish;
    end

endmodule
